FILE: src/rti_pkg.sv
// Shared types and constants of the ray/triangle intersection pipeline.
`default_nettype none
package rti_pkg;

    localparam int DET_EPS_BITS = 40;
    localparam int T_EPS_BITS   = 20;
    localparam int T_FRAC       = 20;

    localparam logic [DET_EPS_BITS-1:0] DET_EPS_RESET = 40'd10737;
    localparam logic [T_EPS_BITS-1:0]   T_EPS_RESET   = 20'd10;

    // register select, taken from paddr[3]
    typedef enum logic {
        REG_DET_EPS = 1'b0,
        REG_T_EPS   = 1'b1
    } reg_idx_t;

    // load enables of the six pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

endpackage
`default_nettype wire

FILE: src/rti_cross.sv
// Edge vectors (stage 1) and the cross products h and q (stage 2) of one triangle.
`default_nettype none
module rti_cross #(
    parameter int COORD_BITS = 21
) (
    input  wire logic                             aclk,
    input  wire rti_pkg::stage_en_t               en,
    input  wire logic signed [COORD_BITS-1:0]     p  [3],
    input  wire logic signed [COORD_BITS-1:0]     d  [3],
    input  wire logic signed [COORD_BITS-1:0]     v0 [3],
    input  wire logic signed [COORD_BITS-1:0]     v1 [3],
    input  wire logic signed [COORD_BITS-1:0]     v2 [3],
    output logic signed [COORD_BITS:0]            e1_o [3],
    output logic signed [COORD_BITS:0]            e2_o [3],
    output logic signed [COORD_BITS:0]            s_o  [3],
    output logic signed [COORD_BITS:0]            d_o  [3],
    output logic signed [2*COORD_BITS+2:0]        h_o  [3],
    output logic signed [2*COORD_BITS+2:0]        q_o  [3]
);
    localparam int D = COORD_BITS + 1;
    localparam int X = 2 * D + 1;

    logic signed [D-1:0] e1_reg [3];
    logic signed [D-1:0] e2_reg [3];
    logic signed [D-1:0] s_reg  [3];
    logic signed [D-1:0] d_reg  [3];
    logic signed [D-1:0] e1_next [3];
    logic signed [D-1:0] e2_next [3];
    logic signed [D-1:0] s_next  [3];

    logic signed [2*D-1:0] hp [6];
    logic signed [2*D-1:0] qp [6];
    logic signed [X-1:0]   h_next [3];
    logic signed [X-1:0]   q_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1_next[i] = D'(v1[i]) - D'(v0[i]);
            e2_next[i] = D'(v2[i]) - D'(v0[i]);
            s_next[i]  = D'(p[i])  - D'(v0[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= e1_next[i];
                e2_reg[i] <= e2_next[i];
                s_reg[i]  <= s_next[i];
                d_reg[i]  <= D'(d[i]);
            end
        end
    end

    // h = d x e2, q = s x e1
    always_comb begin
        hp[0] = d_reg[1] * e2_reg[2];
        hp[1] = d_reg[2] * e2_reg[1];
        hp[2] = d_reg[2] * e2_reg[0];
        hp[3] = d_reg[0] * e2_reg[2];
        hp[4] = d_reg[0] * e2_reg[1];
        hp[5] = d_reg[1] * e2_reg[0];
        qp[0] = s_reg[1] * e1_reg[2];
        qp[1] = s_reg[2] * e1_reg[1];
        qp[2] = s_reg[2] * e1_reg[0];
        qp[3] = s_reg[0] * e1_reg[2];
        qp[4] = s_reg[0] * e1_reg[1];
        qp[5] = s_reg[1] * e1_reg[0];
        for (int i = 0; i < 3; i++) begin
            h_next[i] = X'(hp[2*i]) - X'(hp[2*i+1]);
            q_next[i] = X'(qp[2*i]) - X'(qp[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int i = 0; i < 3; i++) begin
                e1_o[i] <= e1_reg[i];
                e2_o[i] <= e2_reg[i];
                s_o[i]  <= s_reg[i];
                d_o[i]  <= d_reg[i];
                h_o[i]  <= h_next[i];
                q_o[i]  <= q_next[i];
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/rti_dot.sv
// Four dot products (a, u, v and t numerators): split products (stage 3), sums (stage 4).
`default_nettype none
module rti_dot #(
    parameter int COORD_BITS = 21
) (
    input  wire logic                          aclk,
    input  wire rti_pkg::stage_en_t            en,
    input  wire logic signed [COORD_BITS:0]    e1 [3],
    input  wire logic signed [COORD_BITS:0]    e2 [3],
    input  wire logic signed [COORD_BITS:0]    s  [3],
    input  wire logic signed [COORD_BITS:0]    d  [3],
    input  wire logic signed [2*COORD_BITS+2:0] h [3],
    input  wire logic signed [2*COORD_BITS+2:0] q [3],
    output logic signed [3*COORD_BITS+5:0]     dot_o [4]
);
    localparam int D  = COORD_BITS + 1;
    localparam int X  = 2 * D + 1;
    localparam int P  = D + X;
    localparam int S  = P + 2;
    localparam int L  = X / 2;
    localparam int LW = D + L + 1;
    localparam int HW = D + X - L;

    logic signed [D-1:0]  opa [4][3];
    logic signed [X-1:0]  opb [4][3];
    logic signed [LW-1:0] plo_next [4][3];
    logic signed [HW-1:0] phi_next [4][3];
    logic signed [LW-1:0] plo_reg  [4][3];
    logic signed [HW-1:0] phi_reg  [4][3];
    logic signed [S-1:0]  dot_next [4];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            opa[0][j] = e1[j]; opb[0][j] = h[j];
            opa[1][j] = s[j];  opb[1][j] = h[j];
            opa[2][j] = d[j];  opb[2][j] = q[j];
            opa[3][j] = e2[j]; opb[3][j] = q[j];
        end
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                plo_next[k][j] = opa[k][j] * $signed({1'b0, opb[k][j][L-1:0]});
                phi_next[k][j] = opa[k][j] * $signed(opb[k][j][X-1:L]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dot_next[k] = '0;
            for (int j = 0; j < 3; j++) begin
                dot_next[k] = dot_next[k] + (S'(phi_reg[k][j]) <<< L) + S'(plo_reg[k][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            dot_o <= dot_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/rti_test.sv
// Sign normalising and range tests (stage 5), t threshold compare (stage 6).
`default_nettype none
module rti_test #(
    parameter int COORD_BITS = 21
) (
    input  wire logic                                    aclk,
    input  wire rti_pkg::stage_en_t                      en,
    input  wire logic signed [3*COORD_BITS+5:0]          dot [4],
    input  wire logic [rti_pkg::DET_EPS_BITS-1:0]        det_eps,
    input  wire logic [rti_pkg::T_EPS_BITS-1:0]          t_eps,
    output logic                                         hit_o
);
    localparam int S  = 3 * COORD_BITS + 6;
    localparam int W  = S + 1;
    localparam int K  = W / 2;
    localparam int TB = rti_pkg::T_EPS_BITS;

    logic                 neg;
    logic signed [W-1:0]  am, um, vm, tm;
    logic signed [W:0]    uv;
    logic                 pre_next;
    logic                 pre_reg;
    logic [W-1:0]         tn_reg;
    logic [TB+K-1:0]      plo_reg;
    logic [TB+W-K-1:0]    phi_reg;
    logic [W+TB-1:0]      lhs, rhs;

    always_comb begin
        neg = dot[0][S-1];
        am  = neg ? -W'(dot[0]) : W'(dot[0]);
        um  = neg ? -W'(dot[1]) : W'(dot[1]);
        vm  = neg ? -W'(dot[2]) : W'(dot[2]);
        tm  = neg ? -W'(dot[3]) : W'(dot[3]);
        uv  = (W+1)'(um) + (W+1)'(vm);
        pre_next = (dot[0] != '0)
                 && ({{rti_pkg::DET_EPS_BITS{1'b0}}, am} >= {{W{1'b0}}, det_eps})
                 && !um[W-1] && (um <= am)
                 && !vm[W-1] && (uv <= (W+1)'(am))
                 && !tm[W-1] && (tm != '0);
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            pre_reg <= pre_next;
            tn_reg  <= $unsigned(tm);
            plo_reg <= t_eps * $unsigned(am[K-1:0]);
            phi_reg <= t_eps * $unsigned(am[W-1:K]);
        end
    end

    // t_eps * a < tnum * 2^T_FRAC
    always_comb begin
        lhs = ((W+TB)'(phi_reg) << K) + (W+TB)'(plo_reg);
        rhs = {tn_reg, {rti_pkg::T_FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en.s6) begin
            hit_o <= pre_reg && (lhs < rhs);
        end
    end

endmodule
`default_nettype wire

FILE: src/ray_triangle_intersection.sv
// Top level: ray/triangle (and quad) intersection pipeline with APB register port.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: ray and four vertices, tuser: quad_mode
//  m_axis    out  m_axis_tvalid/tready      tdata: hit
//  apb       in   psel/penable/pready       det_epsilon @0x0, t_epsilon @0x8
//
// Six register stages: edges, cross products, split dot products, dot sums,
// sign and range tests, t threshold. One transaction is taken every cycle
// while m_axis_tready does not stall the stage-6 output register.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled, so an empty stage
// still takes data; s_axis_tready drops only when all six stages are full.
`default_nettype none
module ray_triangle_intersection #(
    parameter int COORD_BITS = 21
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, vertex_zero,
    // vertex_one, vertex_two, vertex_three (lowest first), zero filled
    input  wire logic [((18*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // quad_mode
    input  wire logic [0:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // hit, zero filled
    output logic [7:0]               m_axis_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [63:0]         pwdata,
    output logic [63:0]              prdata,
    output logic                     pready
);
    localparam int C = COORD_BITS;
    localparam int D = C + 1;
    localparam int X = 2 * D + 1;
    localparam int S = 3 * C + 6;

    // ---------------- registers ----------------
    logic [rti_pkg::DET_EPS_BITS-1:0] det_eps_reg;
    logic [rti_pkg::T_EPS_BITS-1:0]   t_eps_reg;
    logic                             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_eps_reg <= rti_pkg::DET_EPS_RESET;
            t_eps_reg   <= rti_pkg::T_EPS_RESET;
        end else if (wr) begin
            unique case (rti_pkg::reg_idx_t'(paddr[3]))
                rti_pkg::REG_DET_EPS: det_eps_reg <= pwdata[rti_pkg::DET_EPS_BITS-1:0];
                rti_pkg::REG_T_EPS:   t_eps_reg   <= pwdata[rti_pkg::T_EPS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rti_pkg::reg_idx_t'(paddr[3]))
            rti_pkg::REG_DET_EPS: prdata = 64'(det_eps_reg);
            rti_pkg::REG_T_EPS:   prdata = 64'(t_eps_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------- stage control ----------------
    logic [6:1] v_reg;
    logic [6:1] quad_reg;
    logic [6:1] rdy;
    rti_pkg::stage_en_t en;

    always_comb begin
        rdy[6] = !v_reg[6] || m_axis_tready;
        for (int k = 5; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        en.s1 = rdy[1];
        en.s2 = rdy[2];
        en.s3 = rdy[3];
        en.s4 = rdy[4];
        en.s5 = rdy[5];
        en.s6 = rdy[6];
    end

    assign s_axis_tready = rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) v_reg[1] <= s_axis_tvalid;
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // quad flag travels beside the data
    always_ff @(posedge aclk) begin
        if (rdy[1]) quad_reg[1] <= s_axis_tuser[0];
        for (int k = 2; k <= 6; k++) begin
            if (rdy[k]) quad_reg[k] <= quad_reg[k-1];
        end
    end

    // ---------------- unpack ----------------
    logic signed [C-1:0] p  [3];
    logic signed [C-1:0] d  [3];
    logic signed [C-1:0] vx [4][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p[i] = s_axis_tdata[i*C +: C];
            d[i] = s_axis_tdata[(3+i)*C +: C];
        end
        for (int n = 0; n < 4; n++) begin
            for (int i = 0; i < 3; i++) begin
                vx[n][i] = s_axis_tdata[(6+3*n+i)*C +: C];
            end
        end
    end

    // ---------------- two triangle lanes ----------------
    logic signed [D-1:0] e1 [2][3];
    logic signed [D-1:0] e2 [2][3];
    logic signed [D-1:0] sv [2][3];
    logic signed [D-1:0] dv [2][3];
    logic signed [X-1:0] h  [2][3];
    logic signed [X-1:0] q  [2][3];
    logic signed [S-1:0] dot [2][4];
    logic [1:0]          hit;

    for (genvar g = 0; g < 2; g++) begin : g_lane
        // lane 0: v0 v1 v2, lane 1: v1 v2 v3
        rti_cross #(.COORD_BITS(C)) u_cross (
            .aclk (aclk), .en (en),
            .p (p), .d (d), .v0 (vx[g]), .v1 (vx[g+1]), .v2 (vx[g+2]),
            .e1_o (e1[g]), .e2_o (e2[g]), .s_o (sv[g]), .d_o (dv[g]),
            .h_o (h[g]), .q_o (q[g])
        );
        rti_dot #(.COORD_BITS(C)) u_dot (
            .aclk (aclk), .en (en),
            .e1 (e1[g]), .e2 (e2[g]), .s (sv[g]), .d (dv[g]),
            .h (h[g]), .q (q[g]), .dot_o (dot[g])
        );
        rti_test #(.COORD_BITS(C)) u_test (
            .aclk (aclk), .en (en), .dot (dot[g]),
            .det_eps (det_eps_reg), .t_eps (t_eps_reg), .hit_o (hit[g])
        );
    end

    // ---------------- output ----------------
    assign m_axis_tvalid = v_reg[6];
    assign m_axis_tdata  = {7'b0, hit[0] || (quad_reg[6] && hit[1])};

    // ---------------- assertions ----------------
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> (v_reg == '0))
        else $error("stage valid bits not cleared by reset");
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[1])
        else $error("accepted transaction lost at stage 1");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[5] && v_reg[6] && !m_axis_tready) |=> (v_reg[5] && $stable(quad_reg[5])))
        else $error("stage 5 moved while stage 6 stalled");

endmodule
`default_nettype wire
